[rtl/bpdc_pkg.sv]
// Shared types, codes and constants of the bond price, duration and convexity core.
// Used by bpdc_div and bond_price_duration_convexity_core.
package bpdc_pkg;

  localparam int EXPONENT_BITS_DEF = 9;
  localparam int DEN_W = 82;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [47:0] PRICE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] CVX_MULT = 64'd6553600;

  typedef enum logic [1:0] {
    REG_FACE  = 2'd0,
    REG_PER   = 2'd1,
    REG_SHIFT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_LOW = 2'd1,
    ST_SAT = 2'd2
  } status_t;

endpackage

[rtl/bond_price_duration_convexity_core.sv]
// Top level of the bond price, duration and convexity core: sequencer and registers.
// Depends on bpdc_pkg, bpdc_mul and bpdc_div.
//
// A request on the s_ channel carries maturity, yield and coupon. The core prices the
// bond at the yield and, unless the yield does not exceed the shift, at the yield plus
// and minus the shift, then forms duration and convexity. One result leaves on the m_
// channel per request. All work runs through one multiplier and one divider under a
// sequencer. Each pricing pass runs an exponent loop of up to 2*EXPONENT_BITS
// multiplies. s_tready is high only when the core is idle. The result sits in an
// output register; the core takes the next request while it waits, and finishes that
// request only once the register is free, so a stalled receiver holds results
// without loss. The cfg channel is always ready and should be written only while
// idle. Reset empties the core and loads face value 100, one period a year and a
// shift of one percent.
module bond_price_duration_convexity_core import bpdc_pkg::*; #(
  parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [71:0]   s_tdata,   // years[5:0], yield_rate[37:6], coupon_rate[69:38]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // price[47:0], duration[79:48], convexity[111:80]
  output logic [1:0]    m_tuser,   // status[1:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int BW = $clog2(EXPONENT_BITS);
  localparam int NW = (EXPONENT_BITS > 10) ? EXPONENT_BITS : 10;
  localparam logic [NW-1:0] NMAX = NW'((1 << EXPONENT_BITS) - 1);

  typedef enum logic [15:0] {
    IDLE     = 16'h0001,
    SETUP    = 16'h0002,
    R_DIV    = 16'h0004,
    D_DIV    = 16'h0008,
    SQ_MUL   = 16'h0010,
    DM_MUL   = 16'h0020,
    ANN_DIV  = 16'h0040,
    CF_MUL   = 16'h0080,
    CT_MUL   = 16'h0100,
    FT_MUL   = 16'h0200,
    SUM      = 16'h0400,
    DUR_MUL  = 16'h0800,
    DUR_DIV  = 16'h1000,
    CVX_MUL  = 16'h2000,
    CVX_DIV  = 16'h4000,
    DONE     = 16'h8000
  } state_t;

  typedef enum logic [1:0] {
    PASS_BASE = 2'd0,
    PASS_UP   = 2'd1,
    PASS_DOWN = 2'd2
  } pass_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } fig_t;

  function automatic fig_t fig_cap(input logic [63:0] q, input logic neg);
    fig_t f;
    f.sat = 1'b0;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        f.val = 32'h8000_0000;
        f.sat = 1'b1;
      end else begin
        f.val = 32'd0 - q[31:0];
      end
    end else begin
      if (q > 64'h7FFF_FFFF) begin
        f.val = 32'h7FFF_FFFF;
        f.sat = 1'b1;
      end else begin
        f.val = q[31:0];
      end
    end
    return f;
  endfunction

  state_t state;
  pass_t  pass;
  logic   pend;

  logic [15:0] face;
  logic [3:0]  per;
  logic [31:0] shift;

  logic [5:0]  years_q;
  logic [31:0] yld;
  logic [31:0] cpn;

  logic [EXPONENT_BITS-1:0] n;
  logic [BW-1:0] bidx;
  logic [32:0] yv;
  logic [32:0] r;
  logic [31:0] d;
  logic [32:0] dn;
  logic [63:0] ann;
  logic [47:0] cf;
  logic [63:0] ct;
  logic [31:0] ft;
  logic [47:0] p0;
  logic [47:0] pp;
  logic [47:0] pm;
  logic [DEN_W-1:0] dden;
  logic [79:0] cnum;
  logic [31:0] dur;
  logic [31:0] cvx;
  logic        sat;
  logic        low;

  logic [3:0]    per_e;
  logic [9:0]    nfull;
  logic [NW-1:0] nwide;
  logic [32:0]   om;
  logic [48:0]   total;
  logic [47:0]   price_now;
  logic          price_sat;
  logic [49:0]   dsg;
  logic [48:0]   dmag;
  logic [50:0]   csg;
  logic [50:0]   cmag;
  logic [48:0]   p0x2;
  fig_t          fig_dur;
  fig_t          fig_cvx;

  logic         mul_start;
  logic         mul_done;
  logic         div_start;
  logic         div_done;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [127:0] prod;
  logic [63:0]  num_hi;
  logic [63:0]  num_lo;
  logic [DEN_W-1:0] den;
  logic [63:0]  quo;

  assign s_tready = (state == IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    per_e = (per == 4'd0) ? 4'd1 : per;
    nfull = 10'(years_q) * 10'(per_e);
    nwide = NW'(nfull);
    om = ONE_Q32 - dn;
    p0x2 = {p0, 1'b0};
    dsg = {2'b00, pm} - {2'b00, pp};
    dmag = dsg[49] ? 49'(50'd0 - dsg) : dsg[48:0];
    csg = {3'b000, pm} + {3'b000, pp} - {2'b00, p0x2};
    cmag = csg[50] ? 51'd0 - csg : csg;
    fig_dur = fig_cap(quo, dsg[49]);
    fig_cvx = fig_cap(quo, csg[50]);
    total = {1'b0, ct[47:0]} + {17'd0, ft};
    if (ct[63:48] != 16'd0 || total[48]) begin
      price_now = PRICE_MAX;
      price_sat = 1'b1;
    end else begin
      price_now = total[47:0];
      price_sat = 1'b0;
    end
  end

  always_comb begin
    mul_a = 64'd0;
    mul_b = 64'd0;
    num_hi = 64'd0;
    num_lo = 64'd0;
    den = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      R_DIV: begin
        num_lo = 64'(yv);
        den = DEN_W'(per_e);
        div_start = !pend;
      end
      D_DIV: begin
        num_hi = 64'd1;
        den = DEN_W'({1'b0, ONE_Q32} + {1'b0, r});
        div_start = !pend;
      end
      SQ_MUL: begin
        mul_a = 64'(dn);
        mul_b = 64'(dn);
        mul_start = !pend;
      end
      DM_MUL: begin
        mul_a = 64'(dn);
        mul_b = 64'(d);
        mul_start = !pend;
      end
      ANN_DIV: begin
        num_hi = 64'(om[32]);
        num_lo = {om[31:0], 32'd0};
        den = DEN_W'(r);
        div_start = !pend;
      end
      CF_MUL: begin
        mul_a = 64'(cpn);
        mul_b = 64'(face);
        mul_start = !pend;
      end
      CT_MUL: begin
        mul_a = 64'(cf);
        mul_b = ann;
        mul_start = !pend;
      end
      FT_MUL: begin
        mul_a = 64'(face);
        mul_b = 64'(dn);
        mul_start = !pend;
      end
      DUR_MUL: begin
        mul_a = 64'(p0x2);
        mul_b = 64'(shift);
        mul_start = !pend;
      end
      DUR_DIV: begin
        num_hi = 64'(dmag[48:16]);
        num_lo = {dmag[15:0], 48'd0};
        den = dden;
        div_start = !pend && (dden != '0);
      end
      CVX_MUL: begin
        mul_a = 64'(cmag);
        mul_b = CVX_MULT;
        mul_start = !pend;
      end
      CVX_DIV: begin
        num_hi = 64'(cnum[79:64]);
        num_lo = cnum[63:0];
        den = DEN_W'(p0x2);
        div_start = !pend && (p0 != 48'd0);
      end
      default: begin
      end
    endcase
  end

  bpdc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  bpdc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_hi(num_hi),
    .num_lo(num_lo),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      face <= 16'd100;
      per <= 4'd1;
      shift <= 32'd42949673;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FACE:  face <= cfg_data[15:0];
        REG_PER:   per <= cfg_data[3:0];
        REG_SHIFT: shift <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      if (mul_start || div_start) begin
        pend <= 1'b1;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            years_q <= s_tdata[5:0];
            yld <= s_tdata[37:6];
            cpn <= s_tdata[69:38];
            state <= SETUP;
          end
        end
        SETUP: begin
          n <= (nwide > NMAX) ? NMAX[EXPONENT_BITS-1:0] : nwide[EXPONENT_BITS-1:0];
          pass <= PASS_BASE;
          yv <= {1'b0, yld};
          sat <= 1'b0;
          low <= (yld <= shift);
          dur <= 32'd0;
          cvx <= 32'd0;
          state <= R_DIV;
        end
        R_DIV: begin
          if (div_done) begin
            pend <= 1'b0;
            r <= quo[32:0];
            if (quo == 64'd0) begin
              dn <= ONE_Q32;
              ann <= 64'(n) << 32;
              state <= CF_MUL;
            end else begin
              state <= D_DIV;
            end
          end
        end
        D_DIV: begin
          if (div_done) begin
            pend <= 1'b0;
            d <= quo[31:0];
            dn <= ONE_Q32;
            bidx <= BW'(EXPONENT_BITS - 1);
            state <= SQ_MUL;
          end
        end
        SQ_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            dn <= prod[64:32];
            if (n[bidx]) begin
              state <= DM_MUL;
            end else if (bidx == '0) begin
              state <= ANN_DIV;
            end else begin
              bidx <= bidx - BW'(1);
            end
          end
        end
        DM_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            dn <= prod[64:32];
            if (bidx == '0) begin
              state <= ANN_DIV;
            end else begin
              bidx <= bidx - BW'(1);
              state <= SQ_MUL;
            end
          end
        end
        ANN_DIV: begin
          if (div_done) begin
            pend <= 1'b0;
            ann <= quo;
            state <= CF_MUL;
          end
        end
        CF_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            cf <= prod[47:0];
            state <= CT_MUL;
          end
        end
        CT_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            ct <= prod[111:48];
            state <= FT_MUL;
          end
        end
        FT_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            ft <= prod[47:16];
            state <= SUM;
          end
        end
        SUM: begin
          if (price_sat) begin
            sat <= 1'b1;
          end
          case (pass)
            PASS_BASE: begin
              p0 <= price_now;
              if (low) begin
                state <= DONE;
              end else begin
                pass <= PASS_UP;
                yv <= {1'b0, yld} + {1'b0, shift};
                state <= R_DIV;
              end
            end
            PASS_UP: begin
              pp <= price_now;
              pass <= PASS_DOWN;
              yv <= {1'b0, yld} - {1'b0, shift};
              state <= R_DIV;
            end
            default: begin
              pm <= price_now;
              state <= DUR_MUL;
            end
          endcase
        end
        DUR_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            dden <= prod[DEN_W-1:0];
            state <= DUR_DIV;
          end
        end
        DUR_DIV: begin
          if (!pend && dden == '0) begin
            sat <= 1'b1;
            state <= CVX_MUL;
          end else if (div_done) begin
            pend <= 1'b0;
            dur <= fig_dur.val;
            if (fig_dur.sat) begin
              sat <= 1'b1;
            end
            state <= CVX_MUL;
          end
        end
        CVX_MUL: begin
          if (mul_done) begin
            pend <= 1'b0;
            cnum <= prod[79:0];
            state <= CVX_DIV;
          end
        end
        CVX_DIV: begin
          if (!pend && p0 == 48'd0) begin
            sat <= 1'b1;
            state <= DONE;
          end else if (div_done) begin
            pend <= 1'b0;
            cvx <= fig_cvx.val;
            if (fig_cvx.sat) begin
              sat <= 1'b1;
            end
            state <= DONE;
          end
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {cvx, dur, p0};
            m_tuser <= low ? ST_LOW : (sat ? ST_SAT : ST_OK);
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bpdc_mul.sv]
// Iterative 64x64 multiplier built from one 32x32 multiplier, one partial product at a time.
// Stand-alone; it takes nothing from the package.
module bpdc_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  prod
);

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] pp;
  logic [127:0] addend;

  always_comb begin
    op_a = cnt[1] ? a_q[63:32] : a_q[31:0];
    op_b = cnt[0] ? b_q[63:32] : b_q[31:0];
    pp = op_a * op_b;
    case (cnt)
      2'd0: addend = {64'd0, pp};
      2'd1, 2'd2: addend = {32'd0, pp, 32'd0};
      2'd3: addend = {pp, 64'd0};
      default: addend = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 2'd0;
        a_q <= a;
        b_q <= b;
        prod <= 128'd0;
      end else if (busy) begin
        prod <= prod + addend;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/bpdc_div.sv]
// Restoring divider, one quotient bit a cycle, 128-bit dividend over DEN_W-bit divisor.
// A zero divisor or a quotient of 2^64 or more gives all ones. Depends on bpdc_pkg.
module bpdc_div import bpdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      num_hi,
  input  logic [63:0]      num_lo,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [63:0]      quo
);

  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem;
  logic [63:0]      lo;
  logic [5:0]       cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, lo[63]};
    fits = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q <= den;
        if (den == '0 || {{(DEN_W-64){1'b0}}, num_hi} >= den) begin
          quo <= '1;
          done <= 1'b1;
        end else begin
          rem <= DEN_W'(num_hi);
          lo <= num_lo;
          cnt <= 6'd63;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        lo <= {lo[62:0], 1'b0};
        quo <= {quo[62:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
